// ===== hw/rtl/xxh_pkg.sv =====
// ----------------------------------------------------------------------------
// XXH64 hash unit package
// Shared types, hash primes and rotate helper for the XXH64 stream hash unit.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
    localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] XP12 = XP1 + XP2;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [63:0] word;
        logic [31:0] seed;
        logic        first;
        logic        last;
        logic        take_full;
        logic [2:0]  tail_bytes;
    } xxh_item_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

endpackage

// ===== hw/rtl/xxh_front.sv =====
// ----------------------------------------------------------------------------
// XXH64 front end
// Accepts input requests, saturates the byte count and classifies each word
// as a full word or a tail before pushing it into the queue.
// ----------------------------------------------------------------------------
module xxh_front
    import xxh_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] word,
    input  logic [3:0]  valid_bytes,
    input  logic        first,
    input  logic        last,
    input  logic [31:0] seed,
    output logic        push,
    output xxh_item_t   push_item,
    input  logic        q_full
);

    logic [3:0] vb_sat;

    always_comb
    begin
        vb_sat = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        push_item.word = word;
        push_item.seed = seed;
        push_item.first = first;
        push_item.last = last;
        // A last word with all eight bytes is absorbed like any other word.
        push_item.take_full = !last || (vb_sat == 4'd8);
        push_item.tail_bytes = (last && vb_sat != 4'd8) ? vb_sat[2:0] : 3'd0;
    end

    assign in_ready = !q_full;
    assign push = in_valid && !q_full;

endmodule

// ===== hw/rtl/xxh_fifo.sv =====
// ----------------------------------------------------------------------------
// XXH64 request queue
// Short register queue between the front end and the hash engine.
// ----------------------------------------------------------------------------
module xxh_fifo
    import xxh_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  xxh_item_t push_item,
    input  logic      pop,
    output xxh_item_t pop_item,
    output logic      full,
    output logic      not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xxh_item_t        mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/xxh_back.sv =====
// ----------------------------------------------------------------------------
// XXH64 hash engine
// Sequencer around one shared 32x32 multiplier that runs the lane rounds,
// the lane merge, the tail folding and the avalanche, and holds the digest.
// ----------------------------------------------------------------------------
module xxh_back
    import xxh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  xxh_item_t   q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TAKE   = 5'd1;
    localparam logic [4:0] S_LR0    = 5'd2;
    localparam logic [4:0] S_LR1    = 5'd3;
    localparam logic [4:0] S_LR2    = 5'd4;
    localparam logic [4:0] S_AFTER  = 5'd5;
    localparam logic [4:0] S_FIN    = 5'd6;
    localparam logic [4:0] S_MRG0   = 5'd7;
    localparam logic [4:0] S_MRG1   = 5'd8;
    localparam logic [4:0] S_MRG2   = 5'd9;
    localparam logic [4:0] S_MRG3   = 5'd10;
    localparam logic [4:0] S_ADDTOT = 5'd11;
    localparam logic [4:0] S_BUF0   = 5'd12;
    localparam logic [4:0] S_BUF1   = 5'd13;
    localparam logic [4:0] S_BUF2   = 5'd14;
    localparam logic [4:0] S_BUF3   = 5'd15;
    localparam logic [4:0] S_TL4    = 5'd16;
    localparam logic [4:0] S_TL41   = 5'd17;
    localparam logic [4:0] S_TL42   = 5'd18;
    localparam logic [4:0] S_BYTE0  = 5'd19;
    localparam logic [4:0] S_BYTE1  = 5'd20;
    localparam logic [4:0] S_BYTE2  = 5'd21;
    localparam logic [4:0] S_AV0    = 5'd22;
    localparam logic [4:0] S_AV1    = 5'd23;
    localparam logic [4:0] S_AV2    = 5'd24;
    localparam logic [4:0] S_EMIT   = 5'd25;
    localparam logic [4:0] S_MUL    = 5'd26;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  ret_reg, ret_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [63:0] mula_reg, mula_next;
    logic [63:0] mulb_reg, mulb_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] h_reg, h_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] lane_reg [4];
    logic [63:0] lane_next [4];
    logic [63:0] buf_reg [3];
    logic [63:0] buf_next [3];
    logic [1:0]  wis_reg, wis_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] seed_reg, seed_next;
    logic        fss_reg, fss_next;
    xxh_item_t   cur_reg, cur_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] digest_reg, digest_next;

    logic [31:0] mx, my;
    logic [63:0] mprod;
    logic [63:0] lane_rd, buf_rd, word_in, t0, t1;
    logic        emit_go;

    assign out_valid = out_valid_reg;
    assign digest = digest_reg;

    // Low 64 bits of a 64x64 product in three passes of a 32x32 multiplier.
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mx = mula_reg[31:0];
                my = mulb_reg[31:0];
            end
            2'd1:
            begin
                mx = mula_reg[31:0];
                my = mulb_reg[63:32];
            end
            default:
            begin
                mx = mula_reg[63:32];
                my = mulb_reg[31:0];
            end
        endcase
        mprod = 64'(mx) * 64'(my);
    end

    always_comb
    begin
        lane_rd = lane_reg[idx_reg[1:0]];
        buf_rd = (idx_reg[1:0] == 2'd3) ? cur_reg.word : buf_reg[idx_reg[1:0]];
        word_in = buf_rd;
        emit_go = !out_valid_reg || out_ready;
        t0 = '0;
        t1 = '0;

        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        mula_next = mula_reg;
        mulb_next = mulb_reg;
        prod_next = prod_reg;
        h_next = h_reg;
        idx_next = idx_reg;
        lane_next = lane_reg;
        buf_next = buf_reg;
        wis_next = wis_reg;
        total_next = total_reg;
        seed_next = seed_reg;
        fss_next = fss_reg;
        cur_next = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digest_next = digest_reg;
        q_pop = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cur_next = q_item;
                    if (q_item.first)
                    begin
                        seed_next = q_item.seed;
                        lane_next[0] = {32'd0, q_item.seed} + XP12;
                        lane_next[1] = {32'd0, q_item.seed} + XP2;
                        lane_next[2] = {32'd0, q_item.seed};
                        lane_next[3] = {32'd0, q_item.seed} - XP1;
                        wis_next = '0;
                        total_next = '0;
                        fss_next = 1'b0;
                    end
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                if (!cur_reg.take_full)
                begin
                    state_next = S_AFTER;
                end
                else if (wis_reg != 2'd3)
                begin
                    buf_next[wis_reg] = cur_reg.word;
                    wis_next = wis_reg + 2'd1;
                    total_next = total_reg + 64'd8;
                    state_next = S_AFTER;
                end
                else
                begin
                    idx_next = '0;
                    state_next = S_LR0;
                end
            end
            S_LR0:
            begin
                mula_next = word_in;
                mulb_next = XP2;
                ret_next = S_LR1;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_LR1:
            begin
                mula_next = rotl64(lane_rd + prod_reg, 31);
                mulb_next = XP1;
                ret_next = S_LR2;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_LR2:
            begin
                lane_next[idx_reg[1:0]] = prod_reg;
                if (idx_reg[1:0] == 2'd3)
                begin
                    wis_next = '0;
                    fss_next = 1'b1;
                    total_next = total_reg + 64'd8;
                    state_next = S_AFTER;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                    state_next = S_LR0;
                end
            end
            S_AFTER:
            begin
                total_next = total_reg + 64'(cur_reg.tail_bytes);
                state_next = cur_reg.last ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                idx_next = '0;
                if (total_reg == 64'd0)
                begin
                    h_next = {32'd0, seed_reg};
                    state_next = S_EMIT;
                end
                else if (fss_reg)
                begin
                    h_next = rotl64(lane_reg[0], 1) + rotl64(lane_reg[1], 7)
                           + rotl64(lane_reg[2], 12) + rotl64(lane_reg[3], 18);
                    state_next = S_MRG0;
                end
                else
                begin
                    h_next = {32'd0, seed_reg} + XP5;
                    state_next = S_ADDTOT;
                end
            end
            S_MRG0:
            begin
                mula_next = lane_rd;
                mulb_next = XP2;
                ret_next = S_MRG1;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_MRG1:
            begin
                mula_next = rotl64(prod_reg, 31);
                mulb_next = XP1;
                ret_next = S_MRG2;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_MRG2:
            begin
                t0 = h_reg ^ prod_reg;
                h_next = t0;
                mula_next = t0;
                mulb_next = XP1;
                ret_next = S_MRG3;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_MRG3:
            begin
                h_next = prod_reg + XP4;
                if (idx_reg[1:0] == 2'd3)
                begin
                    state_next = S_ADDTOT;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                    state_next = S_MRG0;
                end
            end
            S_ADDTOT:
            begin
                h_next = h_reg + total_reg;
                idx_next = '0;
                state_next = S_BUF0;
            end
            S_BUF0:
            begin
                if (idx_reg[1:0] < wis_reg)
                begin
                    mula_next = buf_rd;
                    mulb_next = XP2;
                    ret_next = S_BUF1;
                    cnt_next = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_TL4;
                end
            end
            S_BUF1:
            begin
                mula_next = rotl64(prod_reg, 31);
                mulb_next = XP1;
                ret_next = S_BUF2;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_BUF2:
            begin
                t0 = h_reg ^ prod_reg;
                mula_next = rotl64(t0, 27);
                mulb_next = XP1;
                ret_next = S_BUF3;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_BUF3:
            begin
                h_next = prod_reg + XP4;
                idx_next = idx_reg + 3'd1;
                state_next = S_BUF0;
            end
            S_TL4:
            begin
                idx_next = '0;
                if (cur_reg.tail_bytes >= 3'd4)
                begin
                    mula_next = {32'd0, cur_reg.word[31:0]};
                    mulb_next = XP1;
                    ret_next = S_TL41;
                    cnt_next = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_BYTE0;
                end
            end
            S_TL41:
            begin
                t0 = h_reg ^ prod_reg;
                mula_next = rotl64(t0, 23);
                mulb_next = XP2;
                ret_next = S_TL42;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_TL42:
            begin
                h_next = prod_reg + XP3;
                idx_next = 3'd4;
                state_next = S_BYTE0;
            end
            S_BYTE0:
            begin
                if (idx_reg < cur_reg.tail_bytes)
                begin
                    t1 = cur_reg.word >> {idx_reg, 3'b000};
                    mula_next = {56'd0, t1[7:0]};
                    mulb_next = XP5;
                    ret_next = S_BYTE1;
                    cnt_next = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_AV0;
                end
            end
            S_BYTE1:
            begin
                t0 = h_reg ^ prod_reg;
                mula_next = rotl64(t0, 11);
                mulb_next = XP1;
                ret_next = S_BYTE2;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_BYTE2:
            begin
                h_next = prod_reg;
                idx_next = idx_reg + 3'd1;
                state_next = S_BYTE0;
            end
            S_AV0:
            begin
                mula_next = h_reg ^ (h_reg >> 33);
                mulb_next = XP2;
                ret_next = S_AV1;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_AV1:
            begin
                mula_next = prod_reg ^ (prod_reg >> 29);
                mulb_next = XP3;
                ret_next = S_AV2;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_AV2:
            begin
                h_next = prod_reg ^ (prod_reg >> 32);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    digest_next = h_reg;
                    // A digest returns the lanes, the counters, the seed and the stripe flag to their reset values.
                    for (int i = 0; i < 4; i++)
                    begin
                        lane_next[i] = '0;
                    end
                    wis_next = '0;
                    total_next = '0;
                    seed_next = '0;
                    fss_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == 2'd0)
                begin
                    prod_next = mprod;
                end
                else
                begin
                    prod_next = {prod_reg[63:32] + mprod[31:0], prod_reg[31:0]};
                end
                if (cnt_reg == 2'd2)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i] <= '0;
            end
            wis_reg <= '0;
            total_reg <= '0;
            seed_reg <= '0;
            fss_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            lane_reg <= lane_next;
            wis_reg <= wis_next;
            total_reg <= total_next;
            seed_reg <= seed_next;
            fss_reg <= fss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mula_reg <= mula_next;
        mulb_reg <= mulb_next;
        prod_reg <= prod_next;
        h_reg <= h_next;
        buf_reg <= buf_next;
        cur_reg <= cur_next;
        digest_reg <= digest_next;
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped outside idle");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg != 2'd3))
        else $error("multiplier pass count out of range");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_go) |=>
            (out_valid_reg && wis_reg == 2'd0 && total_reg == 64'd0 && !fss_reg))
        else $error("digest issued without clearing hash state");

endmodule

// ===== hw/rtl/xxh64_stream_hash_unit.sv =====
// ----------------------------------------------------------------------------
// XXH64 stream hash unit
// Hashes messages that arrive as little-endian 8-byte words into XXH64 digests.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid/in_ready   | word, valid_bytes, first, last, seed
//  out     | output    | out_valid/out_ready | digest
//
// A word that only fills the stripe buffer needs no multiply; a word
// that completes a stripe runs eight 64-bit multiplies.
// Every 64-bit multiply is a set-up state and three 32x32 passes.
// A last word then adds three multiplies per merged lane or buffered word, and two
// for the four-byte tail, for each single byte and for the avalanche.
// Reset clears the control state, the lanes, the byte total and the seed; a held digest stalls only the next digest.
module xxh64_stream_hash_unit
    import xxh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] word,
    input  logic [3:0]  valid_bytes,
    input  logic        first,
    input  logic        last,
    input  logic [31:0] seed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    logic      push;
    xxh_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    xxh_item_t q_item;

    xxh_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .word        (word),
        .valid_bytes (valid_bytes),
        .first       (first),
        .last        (last),
        .seed        (seed),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    xxh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .full      (q_full),
        .not_empty (q_valid)
    );

    xxh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digest    (digest)
    );

endmodule
